// ===== design/frame_silence_classifier_top_macros.svh =====
// Assertion macros shared by the frame silence classifier RTL.
`ifndef FRAME_SILENCE_CLASSIFIER_TOP_MACROS_SVH
`define FRAME_SILENCE_CLASSIFIER_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define FSC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define FSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fsc_pkg.sv =====
// Shared constants, register codes and field widths of the frame silence classifier.
package fsc_pkg;

   localparam int MAX_FRAME_DEFAULT     = 512;
   localparam int SMOOTH_FRAMES_DEFAULT = 40;

   localparam int SAMPLE_W    = 16;
   localparam int FRAME_CFG_W = 10;
   localparam int CROSS_OUT_W = 15;
   localparam int MAG_OUT_W   = 30;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int MIN_FRAME   = 2;

   localparam logic [FRAME_CFG_W-1:0] FRAME_LENGTH_RESET = 10'd320;
   localparam logic [FRAME_CFG_W-1:0] FRAME_HOP_RESET    = 10'd160;
   localparam logic [MAG_OUT_W-1:0]   MAG_OUT_MAX        = {MAG_OUT_W{1'b1}};
   localparam logic [CROSS_OUT_W-1:0] CROSS_OUT_MAX      = {CROSS_OUT_W{1'b1}};

   // Register word index (byte address / 4)
   typedef enum logic [2:0] {
      CSR_DC_OFFSET              = 3'd0,
      CSR_FRAME_LENGTH           = 3'd1,
      CSR_FRAME_HOP              = 3'd2,
      CSR_CROSSING_THRESHOLD     = 3'd3,
      CSR_MAGNITUDE_THRESHOLD    = 3'd4,
      CSR_LOW_CROSSING_THRESHOLD = 3'd5
   } csr_index_type;

endpackage

// ===== design/fsc_req_if.sv =====
// Sample input channel: valid/ready handshake carrying one speech sample.
interface fsc_req_if;
   import fsc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/fsc_rsp_if.sv =====
// Frame result channel: valid/ready handshake carrying one frame decision.
interface fsc_rsp_if;
   import fsc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   silent;
   logic [CROSS_OUT_W-1:0] smoothed_crossings;
   logic [MAG_OUT_W-1:0]   smoothed_magnitude;
   logic                   changed;

   modport source (output valid, output silent, output smoothed_crossings,
                   output smoothed_magnitude, output changed, input ready);
   modport sink   (input valid, input silent, input smoothed_crossings,
                   input smoothed_magnitude, input changed, output ready);
endinterface

// ===== design/fsc_ram.sv =====
// Generic single-write, single-read RAM with registered, read-first output.
module fsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and read on the same edge; a read of the written entry returns old data
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ===== design/frame_silence_classifier_top.sv =====
// Frame silence classifier: crossing and magnitude voice activity detector, top level.
//
//   Channel   Direction  Protocol       Transaction
//   req       in         valid/ready    one signed 16-bit sample
//   rsp       out        valid/ready    silent, smoothed sums, changed flag
//   csr       in         APB-style      write or read of one 32-bit register
//
// Flow: one sample accepted per clock while not stalled; a frame result passes through
//   stages A, B and C before it reaches the output register. The rate is set by the
//   single write/read port pair of the cumulative-sum memory, written once per sample.
// Reset: synchronous; no clearing pass, a fill count masks history not yet written.
// Stalls: the pipeline holds while a frame result waits in its last stage behind a
//   full output register; samples that end no frame keep flowing otherwise.
`include "frame_silence_classifier_top_macros.svh"

module frame_silence_classifier_top #(
   parameter int MAX_FRAME     = fsc_pkg::MAX_FRAME_DEFAULT,
   parameter int SMOOTH_FRAMES = fsc_pkg::SMOOTH_FRAMES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   fsc_req_if.sink                         req,
   fsc_rsp_if.source                       rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fsc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fsc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fsc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import fsc_pkg::*;

   localparam int MAX_MAG = 2 ** (SAMPLE_W - 1);
   localparam int AW      = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
   localparam int LW      = $clog2(MAX_FRAME + 1);
   localparam int CW      = $clog2(MAX_FRAME * MAX_MAG + 1);
   localparam int XW      = $clog2(MAX_FRAME);
   localparam int RW      = CW + XW;
   localparam int FCW     = $clog2(SMOOTH_FRAMES + 1);
   localparam int RPW     = (SMOOTH_FRAMES > 1) ? $clog2(SMOOTH_FRAMES) : 1;
   localparam int SMW     = $clog2(longint'(SMOOTH_FRAMES) * longint'(MAX_FRAME)
                                   * longint'(MAX_MAG) + 1);
   localparam int SCW     = $clog2(SMOOTH_FRAMES * (MAX_FRAME - 1) + 1);
   localparam int CNTW    = (LW > FRAME_CFG_W) ? LW : FRAME_CFG_W;

   // Configuration registers
   logic signed [SAMPLE_W-1:0] dc_offset_ff;
   logic [FRAME_CFG_W-1:0]     frame_length_ff;
   logic [FRAME_CFG_W-1:0]     frame_hop_ff;
   logic [CROSS_OUT_W-1:0]     cross_thr_ff;
   logic [MAG_OUT_W-1:0]       mag_thr_ff;
   logic [CROSS_OUT_W-1:0]     low_thr_ff;
   logic                       cfg_write;
   csr_index_type              cfg_index;

   // Handshake
   logic stall, adv, acc;

   // Input stage
   logic [SAMPLE_W-1:0]    x_u;
   logic                   x_pos;
   logic [SAMPLE_W-1:0]    x_mag;
   logic [LW-1:0]          len_eff;
   logic [FRAME_CFG_W-1:0] hop_eff;
   logic [31:0]            len_wide;
   logic [AW+1:0]          rd_sum;
   logic [AW-1:0]          samp_raddr;
   logic [RW-1:0]          samp_wdata;
   logic [RW-1:0]          samp_rdata;
   logic                   look_valid;
   logic [FRAME_CFG_W-1:0] sc_inc;
   logic [CNTW-1:0]        limit;
   logic                   frame_end;

   logic [AW-1:0]          wp_ff, wp_in;
   logic [LW-1:0]          fill_ff, fill_in;
   logic [FRAME_CFG_W-1:0] sc_ff, sc_in;
   logic [FCW-1:0]         fc_ff, fc_in;
   logic [RPW-1:0]         rwp_ff, rwp_in;
   logic                   prev_pos_ff;
   logic [CW-1:0]          cum_mag_ff, cum_mag_in;
   logic [XW-1:0]          cum_cross_ff, cum_cross_in;

   // Stage A: window sums and ring read-modify-write
   logic           a_frame_ff;
   logic [CW-1:0]  a_cum_mag_ff;
   logic [XW-1:0]  a_cum_cross_ff;
   logic           a_look_ff;
   logic [FCW-1:0] a_fc_ff;
   logic [RPW-1:0] a_ring_addr_ff;
   logic           a_fwd_ff, fwd_in;
   logic [RW-1:0]  a_fwd_data_ff;
   logic [CW-1:0]  look_mag, win_mag, old_mag;
   logic [XW-1:0]  look_cross, win_cross, old_cross;
   logic [RW-1:0]  ring_rdata, ring_raw, ring_wdata;
   logic           ring_we;

   // Stage B: smoothed sums and early-frame scaling
   logic           b_frame_ff;
   logic [CW-1:0]  b_mag_ff, b_old_mag_ff;
   logic [XW-1:0]  b_cross_ff, b_old_cross_ff;
   logic           b_use_sum_ff;
   logic [SMW-1:0] sm_sum_ff, sm_sum_in, scaled_mag;
   logic [SCW-1:0] sc_sum_ff, sc_sum_in, scaled_cross;

   // Stage C: saturation and decision
   logic                   c_frame_ff;
   logic                   c_use_sum_ff;
   logic [SMW-1:0]         c_scaled_mag_ff, sel_mag;
   logic [SCW-1:0]         c_scaled_cross_ff, sel_cross;
   logic [MAG_OUT_W-1:0]   out_mag;
   logic [CROSS_OUT_W-1:0] out_cross;
   logic                   silent_in;
   logic                   prev_silent_ff;

   // Output register
   logic                   rsp_valid_ff;
   logic                   rsp_silent_ff;
   logic                   rsp_changed_ff;
   logic [MAG_OUT_W-1:0]   rsp_mag_ff;
   logic [CROSS_OUT_W-1:0] rsp_cross_ff;

   // ---------------------------------------------------------------- config port
   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready    = 1'b1;

   // Write the addressed register; other addresses are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         dc_offset_ff    <= '0;
         frame_length_ff <= FRAME_LENGTH_RESET;
         frame_hop_ff    <= FRAME_HOP_RESET;
         cross_thr_ff    <= '0;
         mag_thr_ff      <= '0;
         low_thr_ff      <= '0;
      end else if (cfg_write) begin
         case (cfg_index)
            CSR_DC_OFFSET:              dc_offset_ff    <= pwdata[SAMPLE_W-1:0];
            CSR_FRAME_LENGTH:           frame_length_ff <= pwdata[FRAME_CFG_W-1:0];
            CSR_FRAME_HOP:              frame_hop_ff    <= pwdata[FRAME_CFG_W-1:0];
            CSR_CROSSING_THRESHOLD:     cross_thr_ff    <= pwdata[CROSS_OUT_W-1:0];
            CSR_MAGNITUDE_THRESHOLD:    mag_thr_ff      <= pwdata[MAG_OUT_W-1:0];
            CSR_LOW_CROSSING_THRESHOLD: low_thr_ff      <= pwdata[CROSS_OUT_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (cfg_index)
         CSR_DC_OFFSET:              prdata = CSR_DATA_W'($unsigned(dc_offset_ff));
         CSR_FRAME_LENGTH:           prdata = CSR_DATA_W'(frame_length_ff);
         CSR_FRAME_HOP:              prdata = CSR_DATA_W'(frame_hop_ff);
         CSR_CROSSING_THRESHOLD:     prdata = CSR_DATA_W'(cross_thr_ff);
         CSR_MAGNITUDE_THRESHOLD:    prdata = CSR_DATA_W'(mag_thr_ff);
         CSR_LOW_CROSSING_THRESHOLD: prdata = CSR_DATA_W'(low_thr_ff);
         default:                    prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow control
   // Hold everything while a frame result cannot move into a full output register
   assign stall     = c_frame_ff && rsp_valid_ff && !rsp.ready;
   assign adv       = !stall;
   assign req.ready = adv;
   assign acc       = req.valid && adv;

   // ---------------------------------------------------------------- input stage
   // Clamp frame length and hop to their usable ranges
   always_comb begin
      len_wide = 32'(frame_length_ff);
      if (frame_length_ff < FRAME_CFG_W'(MIN_FRAME)) begin
         len_eff = LW'(MIN_FRAME);
      end else if (len_wide > 32'(MAX_FRAME)) begin
         len_eff = LW'(MAX_FRAME);
      end else begin
         len_eff = LW'(frame_length_ff);
      end
      hop_eff = (frame_hop_ff == '0) ? FRAME_CFG_W'(1) : frame_hop_ff;
   end

   // Remove offset, take sign and magnitude, advance cumulative sums and counters
   always_comb begin
      x_u   = req.sample - dc_offset_ff;
      x_pos = (x_u != '0) && !x_u[SAMPLE_W-1];
      x_mag = x_u[SAMPLE_W-1] ? (~x_u + SAMPLE_W'(1)) : x_u;

      cum_mag_in   = cum_mag_ff + CW'(x_mag);
      cum_cross_in = cum_cross_ff + XW'(x_pos ^ prev_pos_ff);
      // Entry j holds the magnitude total before sample j and crossings through j
      samp_wdata   = {cum_mag_ff, cum_cross_in};

      // Look back to the oldest sample of the window
      rd_sum = (AW+2)'(wp_ff) + (AW+2)'(MAX_FRAME + 1) - (AW+2)'(len_eff);
      if (rd_sum >= (AW+2)'(MAX_FRAME)) begin
         samp_raddr = AW'(rd_sum - (AW+2)'(MAX_FRAME));
      end else begin
         samp_raddr = AW'(rd_sum);
      end
      look_valid = ((LW+1)'(fill_ff) + (LW+1)'(1)) >= (LW+1)'(len_eff);

      wp_in   = (wp_ff == AW'(MAX_FRAME - 1)) ? '0 : wp_ff + AW'(1);
      fill_in = (fill_ff == LW'(MAX_FRAME)) ? fill_ff : fill_ff + LW'(1);

      sc_inc    = (sc_ff != '1) ? sc_ff + FRAME_CFG_W'(1) : sc_ff;
      limit     = (fc_ff == '0) ? CNTW'(len_eff) : CNTW'(hop_eff);
      frame_end = CNTW'(sc_inc) >= limit;
      sc_in     = frame_end ? '0 : sc_inc;

      fc_in  = (fc_ff < FCW'(SMOOTH_FRAMES)) ? fc_ff + FCW'(1) : fc_ff;
      rwp_in = (rwp_ff == RPW'(SMOOTH_FRAMES - 1)) ? '0 : rwp_ff + RPW'(1);
   end

   fsc_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_FRAME)
   ) u_sample_ram (
      .clock (clock),
      .we    (acc),
      .waddr (wp_ff),
      .wdata (samp_wdata),
      .re    (acc && frame_end),
      .raddr (samp_raddr),
      .rdata (samp_rdata)
   );

   // ---------------------------------------------------------------- stage A
   always_comb begin
      look_mag   = a_look_ff ? samp_rdata[RW-1:XW] : '0;
      look_cross = a_look_ff ? samp_rdata[XW-1:0] : '0;
      win_mag    = a_cum_mag_ff - look_mag;
      win_cross  = a_cum_cross_ff - look_cross;

      // Ring entries are read as zero until the ring has wrapped once
      ring_raw  = a_fwd_ff ? a_fwd_data_ff : ring_rdata;
      old_mag   = (a_fc_ff == FCW'(SMOOTH_FRAMES)) ? ring_raw[RW-1:XW] : '0;
      old_cross = (a_fc_ff == FCW'(SMOOTH_FRAMES)) ? ring_raw[XW-1:0] : '0;

      ring_we    = adv && a_frame_ff;
      ring_wdata = {win_mag, win_cross};
      // The entry being written is read on the same edge: forward the new value
      fwd_in     = ring_we && (a_ring_addr_ff == rwp_ff);
   end

   fsc_ram #(
      .WIDTH (RW),
      .DEPTH (SMOOTH_FRAMES)
   ) u_ring_ram (
      .clock (clock),
      .we    (ring_we),
      .waddr (a_ring_addr_ff),
      .wdata (ring_wdata),
      .re    (acc && frame_end),
      .raddr (rwp_ff),
      .rdata (ring_rdata)
   );

   // ---------------------------------------------------------------- stage B
   always_comb begin
      sm_sum_in    = sm_sum_ff - SMW'(b_old_mag_ff) + SMW'(b_mag_ff);
      sc_sum_in    = sc_sum_ff - SCW'(b_old_cross_ff) + SCW'(b_cross_ff);
      scaled_mag   = SMW'(b_mag_ff) * SMW'(SMOOTH_FRAMES);
      scaled_cross = SCW'(b_cross_ff) * SCW'(SMOOTH_FRAMES);
   end

   // ---------------------------------------------------------------- stage C
   always_comb begin
      sel_mag   = c_use_sum_ff ? sm_sum_ff : c_scaled_mag_ff;
      sel_cross = c_use_sum_ff ? sc_sum_ff : c_scaled_cross_ff;
      out_mag   = (64'(sel_mag) > 64'(MAG_OUT_MAX)) ? MAG_OUT_MAX : MAG_OUT_W'(sel_mag);
      out_cross = (64'(sel_cross) > 64'(CROSS_OUT_MAX)) ? CROSS_OUT_MAX
                                                        : CROSS_OUT_W'(sel_cross);
      if (cross_thr_ff != '0) begin
         silent_in = (out_cross <= cross_thr_ff) && (out_mag <= mag_thr_ff);
      end else begin
         silent_in = (out_mag <= mag_thr_ff) || (out_cross < low_thr_ff);
      end
   end

   // ---------------------------------------------------------------- control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff          <= '0;
         fill_ff        <= '0;
         sc_ff          <= '0;
         fc_ff          <= '0;
         rwp_ff         <= '0;
         prev_pos_ff    <= 1'b0;
         cum_mag_ff     <= '0;
         cum_cross_ff   <= '0;
         a_frame_ff     <= 1'b0;
         a_fwd_ff       <= 1'b0;
         b_frame_ff     <= 1'b0;
         c_frame_ff     <= 1'b0;
         sm_sum_ff      <= '0;
         sc_sum_ff      <= '0;
         prev_silent_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // Advance per-sample state on each accepted transaction
         if (acc) begin
            wp_ff        <= wp_in;
            fill_ff      <= fill_in;
            sc_ff        <= sc_in;
            prev_pos_ff  <= x_pos;
            cum_mag_ff   <= cum_mag_in;
            cum_cross_ff <= cum_cross_in;
            if (frame_end) begin
               fc_ff  <= fc_in;
               rwp_ff <= rwp_in;
            end
         end
         if (adv) begin
            a_frame_ff <= acc && frame_end;
            a_fwd_ff   <= fwd_in;
            b_frame_ff <= a_frame_ff;
            c_frame_ff <= b_frame_ff;
            if (b_frame_ff) begin
               sm_sum_ff <= sm_sum_in;
               sc_sum_ff <= sc_sum_in;
            end
            if (c_frame_ff) begin
               prev_silent_ff <= silent_in;
            end
         end
         // Load a new result or drop the one taken
         if (adv && c_frame_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (adv) begin
         a_cum_mag_ff      <= cum_mag_in;
         a_cum_cross_ff    <= cum_cross_in;
         a_look_ff         <= look_valid;
         a_fc_ff           <= fc_ff;
         a_ring_addr_ff    <= rwp_ff;
         a_fwd_data_ff     <= ring_wdata;
         b_mag_ff          <= win_mag;
         b_cross_ff        <= win_cross;
         b_old_mag_ff      <= old_mag;
         b_old_cross_ff    <= old_cross;
         b_use_sum_ff      <= a_fc_ff >= FCW'(SMOOTH_FRAMES - 1);
         c_use_sum_ff      <= b_use_sum_ff;
         c_scaled_mag_ff   <= scaled_mag;
         c_scaled_cross_ff <= scaled_cross;
         if (c_frame_ff) begin
            rsp_silent_ff  <= silent_in;
            rsp_changed_ff <= silent_in ^ prev_silent_ff;
            rsp_mag_ff     <= out_mag;
            rsp_cross_ff   <= out_cross;
         end
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.silent             = rsp_silent_ff;
   assign rsp.changed            = rsp_changed_ff;
   assign rsp.smoothed_magnitude = rsp_mag_ff;
   assign rsp.smoothed_crossings = rsp_cross_ff;

   // ---------------------------------------------------------------- assertions
   `FSC_ASSERT_SAME(a_samp_rw_apart, clock, reset, acc && frame_end, samp_raddr != wp_ff, "window look-back hits the entry being written")
   `FSC_ASSERT_NEXT(a_stall_holds, clock, reset, stall, c_frame_ff && rsp_valid_ff, "stalled frame result lost")
   `FSC_ASSERT_SAME(a_rsp_from_frame, clock, reset, $rose(rsp_valid_ff), $past(c_frame_ff), "result appeared without a frame")
   `FSC_ASSERT_SAME(a_fwd_single_ring, clock, reset, a_fwd_ff, SMOOTH_FRAMES == 1, "ring forwarding with distinct entries")

endmodule
